// ----- design/hslca_pkg.sv -----
// ----------------------------------------------------------------------------
// hslca_pkg
// shared widths, fixed-point constants, modes and beat structures of the
// hsl colour adjust block
// ----------------------------------------------------------------------------
package hslca_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int FRAC_W     = 16;
  localparam int ONE_W      = FRAC_W + 1;
  localparam int HUE_W      = 25;
  localparam int DIV_STAGES = 22;
  localparam int QUO_W      = DIV_STAGES;
  localparam int DEN_W      = 9;
  localparam int NUM_W      = QUO_W + DEN_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int ANGLE_W    = 10;
  localparam int PCT_W      = 8;

  localparam logic [HUE_W-1:0] DEG_60  = HUE_W'(60 * 65536);
  localparam logic [HUE_W-1:0] DEG_120 = HUE_W'(120 * 65536);
  localparam logic [HUE_W-1:0] DEG_240 = HUE_W'(240 * 65536);
  localparam logic [HUE_W-1:0] DEG_360 = HUE_W'(360 * 65536);
  localparam logic [ONE_W-1:0] FRAC_ONE = ONE_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    MODE_HUE   = 2'd0,
    MODE_SAT   = 2'd1,
    MODE_LIGHT = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    HUE_BASE_0   = 2'd0,
    HUE_BASE_120 = 2'd1,
    HUE_BASE_240 = 2'd2
  } hue_base_e;

  typedef struct packed {
    logic [NUM_W-1:0] s_num;
    logic [DEN_W-1:0] s_den;
    logic [NUM_W-1:0] h_num;
    logic [DEN_W-1:0] h_den;
    logic             h_neg;
    hue_base_e        h_base;
    logic [ONE_W-1:0] l16;
  } work_t;

  typedef struct packed {
    logic             h_neg;
    hue_base_e        h_base;
    logic [ONE_W-1:0] l16;
  } side_t;

endpackage

// ----- design/hslca_front.sv -----
// ----------------------------------------------------------------------------
// hslca_front
// accepts pixel beats, finds max and min, lightness and the divider operands
// ----------------------------------------------------------------------------
module hslca_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [hslca_pkg::PIX_W-1:0] s_axis_tdata_i, // red, green, blue
  output logic                    vld_o,
  input  logic                    rdy_i,
  output hslca_pkg::work_t        ent_o
);
  import hslca_pkg::*;

  logic [CH_W-1:0] r, g, b, mx, mn, d, a;
  logic [8:0]      sum, den_s;
  logic signed [8:0] n;
  logic [23:0]     lnum;
  logic [55:0]     lprod;
  logic [13:0]     a60;
  hue_base_e       base;
  work_t           ent_d, ent_q;
  logic            vld_q, load;

  always_comb begin
    r = s_axis_tdata_i[CH_W-1:0];
    g = s_axis_tdata_i[2*CH_W-1:CH_W];
    b = s_axis_tdata_i[3*CH_W-1:2*CH_W];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = {1'b0, mx} + {1'b0, mn};
    d = mx - mn;
    lnum = {sum, 15'd0} + 24'd127;
    lprod = lnum * 32'h80808081;
    den_s = (sum < 9'd255) ? sum : (9'd510 - sum);
    if (mx == r) begin
      n = $signed({1'b0, g}) - $signed({1'b0, b});
      base = HUE_BASE_0;
    end else if (mx == g) begin
      n = $signed({1'b0, b}) - $signed({1'b0, r});
      base = HUE_BASE_120;
    end else begin
      n = $signed({1'b0, r}) - $signed({1'b0, g});
      base = HUE_BASE_240;
    end
    a = n[8] ? 8'(-n) : n[7:0];
    a60 = 14'(a * 6'd60);
    ent_d.l16 = lprod[55:39];
    ent_d.h_neg = n[8];
    ent_d.h_base = base;
    if (d == '0) begin
      ent_d.s_num = '0;
      ent_d.s_den = DEN_W'(1);
      ent_d.h_num = '0;
      ent_d.h_den = DEN_W'(1);
    end else begin
      ent_d.s_num = NUM_W'({d, 8'd0, den_s[8:1]});
      ent_d.s_den = den_s;
      ent_d.h_num = NUM_W'({a60, 9'd0, d[7:1]});
      ent_d.h_den = {1'b0, d};
    end
  end

  assign s_axis_tready_o = !vld_q || rdy_i;
  assign load = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= load || (vld_q && !rdy_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) ent_q <= ent_d;
  end

  assign vld_o = vld_q;
  assign ent_o = ent_q;

endmodule

// ----- design/hslca_fifo.sv -----
// ----------------------------------------------------------------------------
// hslca_fifo
// short queue of classified beats between front and back
// ----------------------------------------------------------------------------
module hslca_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hslca_pkg::work_t data_i,
  output logic             rdy_o,
  output logic             vld_o,
  input  logic             pop_i,
  output hslca_pkg::work_t data_o
);
  import hslca_pkg::*;

  work_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic                  do_push, do_pop;

  assign rdy_o   = cnt_q != (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign vld_o   = cnt_q != '0;
  assign do_push = push_i && rdy_o;
  assign do_pop  = pop_i && vld_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= data_i;
  end

endmodule

// ----- design/hslca_div.sv -----
// ----------------------------------------------------------------------------
// hslca_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module hslca_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [hslca_pkg::NUM_W-1:0] num_i,
  input  logic [hslca_pkg::DEN_W-1:0] den_i,
  output logic [hslca_pkg::QUO_W-1:0] quo_o
);
  import hslca_pkg::*;

  logic [DEN_W-1:0] rem_q [DIV_STAGES];
  logic [QUO_W-1:0] low_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic [DEN_W-1:0] rem_p [DIV_STAGES];
  logic [QUO_W-1:0] low_p [DIV_STAGES];
  logic [QUO_W-1:0] quo_p [DIV_STAGES];
  logic [DEN_W-1:0] den_p [DIV_STAGES];
  logic [DEN_W:0]   cand  [DIV_STAGES];
  logic [DEN_W:0]   diff  [DIV_STAGES];

  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        rem_p[i] = num_i[NUM_W-1:QUO_W];
        low_p[i] = num_i[QUO_W-1:0];
        quo_p[i] = '0;
        den_p[i] = den_i;
      end else begin
        rem_p[i] = rem_q[i-1];
        low_p[i] = low_q[i-1];
        quo_p[i] = quo_q[i-1];
        den_p[i] = den_q[i-1];
      end
      cand[i] = {rem_p[i], low_p[i][QUO_W-1]};
      diff[i] = cand[i] - {1'b0, den_p[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        if (cand[i] >= {1'b0, den_p[i]}) begin
          rem_q[i] <= diff[i][DEN_W-1:0];
          quo_q[i] <= {quo_p[i][QUO_W-2:0], 1'b1};
        end else begin
          rem_q[i] <= cand[i][DEN_W-1:0];
          quo_q[i] <= {quo_p[i][QUO_W-2:0], 1'b0};
        end
        low_q[i] <= {low_p[i][QUO_W-2:0], 1'b0};
        den_q[i] <= den_p[i];
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

// ----- design/hslca_back.sv -----
// ----------------------------------------------------------------------------
// hslca_back
// divides out hue and saturation, applies the adjustment and converts back
// ----------------------------------------------------------------------------
module hslca_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  hslca_pkg::work_t               ent_i,
  output logic                           pop_o,
  input  hslca_pkg::mode_e               mode_i,
  input  logic [hslca_pkg::ANGLE_W-1:0]  angle_i,
  input  logic [hslca_pkg::PCT_W-1:0]    percent_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [hslca_pkg::PIX_W-1:0]    m_axis_tdata_o // red, green, blue
);
  import hslca_pkg::*;

  function automatic logic [CH_W-1:0] to_channel(logic [ONE_W-1:0] ch,
                                                 logic [ONE_W-1:0] l,
                                                 logic [ONE_W-1:0] c);
    logic signed [20:0] v;
    logic [26:0]        o;
    v = $signed({3'b0, ch, 1'b0}) + $signed({3'b0, l, 1'b0}) - $signed({4'b0, c});
    o = 27'(v[18:0] * 9'd255) + 27'd65536;
    if (v <= 0) return '0;
    if (o[26:17] > 10'd255) return 8'd255;
    return o[24:17];
  endfunction

  logic             en;
  side_t            side_q [DIV_STAGES];
  logic             sv_q   [DIV_STAGES];
  logic [QUO_W-1:0] quo_s, quo_h;

  logic             p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q, out_v_q;
  logic [HUE_W-1:0] p1_h_q, p2_h_q, p3_h_q;
  logic [ONE_W-1:0] p1_s_q, p2_s_q, p3_s_q, p1_l_q, p2_l_q, p3_l_q;
  logic [ONE_W-1:0] p4_l_q, p5_l_q, p6_l_q, p5_c_q, p6_c_q;
  logic [23:0]      p2_prod_q;
  logic [32:0]      p4_cp_q;
  logic [21:0]      p4_k_q;
  logic [2:0]       p4_sec_q, p5_sec_q, p6_sec_q;
  logic [38:0]      p5_xp_q;
  logic [45:0]      p6_zm_q;
  logic [PIX_W-1:0] out_q;

  logic [HUE_W-1:0]   base_v, h1, hw, base_f, f, h_d;
  logic signed [26:0] hs;
  logic [11:0]        deg;
  logic signed [PCT_W-1:0] pc;
  logic signed [PCT_W:0]   fac9;
  logic [ONE_W-1:0]   sv, q3c, t, c16, x16, rc, gc, bc;
  logic [48:0]        q3p;
  logic [17:0]        q3;
  logic signed [18:0] tt;
  logic [17:0]        ta;
  logic [8:0]         hi;
  logic [2:0]         sec;
  logic signed [26:0] dk;
  logic [24:0]        dka;
  logic [22:0]        z;

  assign en    = !out_v_q || m_axis_tready_i;
  assign pop_o = en && vld_i;

  hslca_div u_div_s (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ent_i.s_num),
    .den_i (ent_i.s_den),
    .quo_o (quo_s)
  );

  hslca_div u_div_h (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ent_i.h_num),
    .den_i (ent_i.h_den),
    .quo_o (quo_h)
  );

  always_comb begin
    unique case (side_q[DIV_STAGES-1].h_base)
      HUE_BASE_120: base_v = DEG_120;
      HUE_BASE_240: base_v = DEG_240;
      default:      base_v = '0;
    endcase
    hs = $signed({2'b00, base_v});
    if (side_q[DIV_STAGES-1].h_neg) hs = hs - $signed({5'b0, quo_h});
    else hs = hs + $signed({5'b0, quo_h});
    if (hs < 0) hs = hs + $signed({2'b00, DEG_360});
    else if (hs >= $signed({2'b00, DEG_360})) hs = hs - $signed({2'b00, DEG_360});
    h1 = hs[HUE_W-1:0];

    deg = 12'({3'b0, p1_h_q[24:16]}) + {{2{angle_i[ANGLE_W-1]}}, angle_i} + 12'd720;
    if (deg >= 12'd1080) deg = deg - 12'd1080;
    if (deg >= 12'd720) deg = deg - 12'd720;
    if (deg >= 12'd360) deg = deg - 12'd360;
    hw = {deg[8:0], p1_h_q[15:0]};

    pc = $signed(percent_i);
    if (pc > 8'sd100) pc = 8'sd100;
    if (pc < -8'sd100) pc = -8'sd100;
    fac9 = 9'sd100 + {pc[PCT_W-1], pc};
    sv = (mode_i == MODE_SAT) ? p1_s_q : p1_l_q;

    q3p = p2_prod_q * 25'd21474837;
    q3 = q3p[48:31];
    q3c = (q3 > 18'(FRAC_ONE)) ? FRAC_ONE : q3[ONE_W-1:0];

    tt = $signed({1'b0, p3_l_q, 1'b0}) - $signed({2'b0, FRAC_ONE});
    ta = tt[18] ? 18'(-tt) : tt[17:0];
    t = 17'(18'(FRAC_ONE) - ta);
    hi = p3_h_q[24:16];
    if (hi >= 9'd300) sec = 3'd5;
    else if (hi >= 9'd240) sec = 3'd4;
    else if (hi >= 9'd180) sec = 3'd3;
    else if (hi >= 9'd120) sec = 3'd2;
    else if (hi >= 9'd60) sec = 3'd1;
    else sec = 3'd0;
    unique case (sec[2:1])
      2'd1:    base_f = DEG_120;
      2'd2:    base_f = DEG_240;
      default: base_f = '0;
    endcase
    f = p3_h_q - base_f;
    dk = $signed({2'b0, f}) - $signed({2'b0, DEG_60});
    dka = dk[26] ? 25'(-dk) : dk[24:0];
    h_d = DEG_60 - dka;

    c16 = p4_cp_q[32:16];
    z = p5_xp_q[38:16];
    x16 = p6_zm_q[44:28];
    unique case (p6_sec_q)
      3'd0:    begin rc = p6_c_q; gc = x16;    bc = '0;     end
      3'd1:    begin rc = x16;    gc = p6_c_q; bc = '0;     end
      3'd2:    begin rc = '0;     gc = p6_c_q; bc = x16;    end
      3'd3:    begin rc = '0;     gc = x16;    bc = p6_c_q; end
      3'd4:    begin rc = x16;    gc = '0;     bc = p6_c_q; end
      default: begin rc = p6_c_q; gc = '0;     bc = x16;    end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STAGES; i++) sv_q[i] <= 1'b0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      p6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sv_q[0] <= vld_i;
      for (int i = 1; i < DIV_STAGES; i++) sv_q[i] <= sv_q[i-1];
      p1_v_q  <= sv_q[DIV_STAGES-1];
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      p5_v_q  <= p4_v_q;
      p6_v_q  <= p5_v_q;
      out_v_q <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{h_neg: ent_i.h_neg, h_base: ent_i.h_base, l16: ent_i.l16};
      for (int i = 1; i < DIV_STAGES; i++) side_q[i] <= side_q[i-1];

      p1_h_q <= h1;
      p1_s_q <= quo_s[ONE_W-1:0];
      p1_l_q <= side_q[DIV_STAGES-1].l16;

      p2_h_q    <= (mode_i == MODE_HUE) ? hw : p1_h_q;
      p2_s_q    <= p1_s_q;
      p2_l_q    <= p1_l_q;
      p2_prod_q <= 24'(sv * fac9[7:0]) + 24'd50;

      p3_h_q <= p2_h_q;
      p3_s_q <= (mode_i == MODE_SAT) ? q3c : p2_s_q;
      p3_l_q <= (mode_i == MODE_LIGHT) ? q3c : p2_l_q;

      p4_cp_q  <= 33'(t * p3_s_q) + 33'd32768;
      p4_k_q   <= h_d[21:0];
      p4_sec_q <= sec;
      p4_l_q   <= p3_l_q;

      p5_xp_q  <= 39'(c16 * p4_k_q) + 39'd1966080;
      p5_c_q   <= c16;
      p5_sec_q <= p4_sec_q;
      p5_l_q   <= p4_l_q;

      p6_zm_q  <= z * 23'd4473925;
      p6_c_q   <= p5_c_q;
      p6_sec_q <= p5_sec_q;
      p6_l_q   <= p5_l_q;

      out_q <= {to_channel(bc, p6_l_q, p6_c_q), to_channel(gc, p6_l_q, p6_c_q),
                to_channel(rc, p6_l_q, p6_c_q)};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ----- design/hsl_color_adjust.sv -----
// throughput: one pixel per cycle while the output is not stalled, set by the fully pipelined
// hue and saturation dividers (22 stages, one quotient bit each) and a back-conversion pipeline
// a 4-entry queue decouples classification from the back pipeline
// reset: asynchronous, active low; clears handshake state and the registers to mode 0,
// angle 0, percent 0
// ----------------------------------------------------------------------------
// hsl_color_adjust
// rgb to hsl, hue rotation, saturation / lightness scaling or no adjustment, hsl back to rgb
// ----------------------------------------------------------------------------
module hsl_color_adjust (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hslca_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hslca_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [hslca_pkg::PIX_W-1:0]        s_axis_tdata_i, // red_in, green_in, blue_in
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [hslca_pkg::PIX_W-1:0]        m_axis_tdata_o  // red_out, green_out, blue_out
);
  import hslca_pkg::*;

  mode_e              mode_q;
  logic [ANGLE_W-1:0] angle_q;
  logic [PCT_W-1:0]   pct_q;
  logic               front_vld, fifo_rdy, fifo_vld, fifo_pop;
  work_t              front_ent, fifo_ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HUE;
      angle_q <= '0;
      pct_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MODE) mode_q <= mode_e'(cfg_data_i[1:0]);
      if (cfg_idx_i == REG_ANGLE) angle_q <= cfg_data_i[ANGLE_W-1:0];
      if (cfg_idx_i == REG_PERCENT) pct_q <= cfg_data_i[PCT_W-1:0];
    end
  end

  hslca_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .vld_o           (front_vld),
    .rdy_i           (fifo_rdy),
    .ent_o           (front_ent)
  );

  hslca_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_vld),
    .data_i (front_ent),
    .rdy_o  (fifo_rdy),
    .vld_o  (fifo_vld),
    .pop_i  (fifo_pop),
    .data_o (fifo_ent)
  );

  hslca_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vld_i           (fifo_vld),
    .ent_i           (fifo_ent),
    .pop_o           (fifo_pop),
    .mode_i          (mode_q),
    .angle_i         (angle_q),
    .percent_i       (pct_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  a_angle_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == REG_ANGLE |=> angle_q == $past(cfg_data_i[ANGLE_W-1:0]))
    else $error("angle register not written");

  a_pct_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == REG_PERCENT |=> pct_q == $past(cfg_data_i[PCT_W-1:0]))
    else $error("percent register not written");

  a_front_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_vld && !fifo_rdy |=> front_vld && $stable(front_ent))
    else $error("front beat lost under backpressure");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsl colour adjust testbench
// drives random and directed pixels through the block under every adjust
// mode and compares each output pixel with a local fixed-point model
// ----------------------------------------------------------------------------
module testbench;
  import hslca_pkg::*;

  localparam longint D1   = 65536;
  localparam longint D60  = 60 * D1;
  localparam longint D360 = 360 * D1;
  localparam int     LIMIT = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [PIX_W-1:0]      s_axis_tdata_i = '0; // red_in, green_in, blue_in
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata_o;      // red_out, green_out, blue_out

  mode_e               cur_mode;
  logic signed [9:0]   cur_angle;
  logic signed [7:0]   cur_pct;
  logic [PIX_W-1:0]    pixel_q[$];
  int                  errors = 0;
  int                  sent = 0;
  int                  seen = 0;
  int                  cycles = 0;
  int                  rx_gap = 0;
  bit                  rx_idle = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  hsl_color_adjust u_top (.*);

  function automatic longint scale_frac(longint v);
    longint p;
    p = cur_pct;
    if (p > 100) p = 100;
    if (p < -100) p = -100;
    v = (v * (100 + p) + 50) / 100;
    if (v > D1) v = D1;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic longint hue_frac(longint n, longint d);
    longint a, q;
    a = n < 0 ? -n : n;
    q = (a * D60 + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic logic [7:0] chan_of(longint ch, longint l, longint c);
    longint v, o;
    v = 2 * ch + 2 * l - c;
    if (v <= 0) return 8'd0;
    o = (v * 255 + 65536) / 131072;
    if (o > 255) o = 255;
    return o[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] adjusted_pixel(logic [PIX_W-1:0] px);
    longint r, g, b, mx, mn, sm, d, h, s, l, t, c, x, k, den, rc, gc, bc;
    r = px[7:0]; g = px[15:8]; b = px[23:16];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sm = mx + mn; d = mx - mn;
    l = (sm * D1 + 255) / 510;
    h = 0; s = 0;
    if (d != 0) begin
      den = sm < 255 ? sm : 510 - sm;
      s = (d * D1 + den / 2) / den;
      if (mx == r) begin
        h = hue_frac(g - b, d);
        if (h < 0) h += D360;
      end else if (mx == g) h = hue_frac(b - r, d) + 2 * D60;
      else h = hue_frac(r - g, d) + 4 * D60;
      if (h >= D360) h -= D360;
    end
    case (cur_mode)
      MODE_HUE:   h = (h + longint'(cur_angle) * D1 + 2 * D360) % D360;
      MODE_SAT:   s = scale_frac(s);
      MODE_LIGHT: l = scale_frac(l);
      default: ;
    endcase
    t = 2 * l - D1;
    if (t < 0) t = -t;
    t = D1 - t;
    c = (t * s + 32768) / 65536;
    k = h % (2 * D60) - D60;
    if (k < 0) k = -k;
    k = D60 - k;
    x = (c * k + D60 / 2) / D60;
    case (h / D60)
      0: begin rc = c; gc = x; bc = 0; end
      1: begin rc = x; gc = c; bc = 0; end
      2: begin rc = 0; gc = c; bc = x; end
      3: begin rc = 0; gc = x; bc = c; end
      4: begin rc = x; gc = 0; bc = c; end
      default: begin rc = c; gc = 0; bc = x; end
    endcase
    return {chan_of(bc, l, c), chan_of(gc, l, c), chan_of(rc, l, c)};
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // output side: stall and check
  always @(posedge clk_i) begin
    logic [PIX_W-1:0] want;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen <= seen + 1;
        if (pixel_q.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata_o);
          errors = errors + 1;
        end else begin
          want = pixel_q.pop_front();
          if (want[7:0] !== m_axis_tdata_o[7:0]) begin
            $error("red_out exp %0d got %0d", want[7:0], m_axis_tdata_o[7:0]);
            errors = errors + 1;
          end
          if (want[15:8] !== m_axis_tdata_o[15:8]) begin
            $error("green_out exp %0d got %0d", want[15:8], m_axis_tdata_o[15:8]);
            errors = errors + 1;
          end
          if (want[23:16] !== m_axis_tdata_o[23:16]) begin
            $error("blue_out exp %0d got %0d", want[23:16], m_axis_tdata_o[23:16]);
            errors = errors + 1;
          end
        end
      end
      if (rx_idle) begin
        m_axis_tready_i <= 1'b1;
      end else if (rx_gap > 0) begin
        m_axis_tready_i <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
        rx_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("hsl_color_adjust: mismatch");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, g, r};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pixel_q.push_back(adjusted_pixel({b, g, r}));
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:    cur_mode = mode_e'(val[1:0]);
      REG_ANGLE:   cur_angle = val[9:0];
      REG_PERCENT: cur_pct = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_all(mode_e m, logic [9:0] a, logic [7:0] p);
    drain();
    write_reg(REG_MODE, CFG_DATA_W'(m));
    write_reg(REG_ANGLE, a);
    write_reg(REG_PERCENT, CFG_DATA_W'(p));
  endtask

  task automatic random_pixels(int n, bit gaps);
    logic [7:0] r, g, b;
    repeat (n) begin
      r = $urandom; g = $urandom; b = $urandom;
      if ($urandom_range(0, 9) == 0) begin g = r; b = r; end
      else if ($urandom_range(0, 9) == 0) g = r;
      send_pixel(r, g, b, gaps);
    end
  endtask

  task automatic test_directed();
    set_all(MODE_HUE, 10'sd0, 8'sd0);
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd128, 8'd128, 8'd128, 0);
    send_pixel(8'd255, 8'd0, 8'd0, 0);
    send_pixel(8'd0, 8'd255, 8'd0, 0);
    send_pixel(8'd0, 8'd0, 8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd0, 0);
    send_pixel(8'd255, 8'd0, 8'd255, 0);
    send_pixel(8'd1, 8'd0, 8'd2, 0);
    send_pixel(8'd200, 8'd50, 8'd100, 0);
    set_all(MODE_HUE, -10'sd360, 8'sd0);
    send_pixel(8'd200, 8'd50, 8'd100, 0);
    set_all(MODE_HUE, 10'sd511, 8'sd0);
    send_pixel(8'd200, 8'd50, 8'd100, 0);
    set_all(MODE_HUE, -10'sd512, 8'sd0);
    send_pixel(8'd30, 8'd220, 8'd90, 0);
    set_all(MODE_SAT, 10'sd0, 8'sd127);
    send_pixel(8'd200, 8'd50, 8'd100, 0);
    send_pixel(8'd90, 8'd90, 8'd90, 0);
    set_all(MODE_SAT, 10'sd0, -8'sd128);
    send_pixel(8'd200, 8'd50, 8'd100, 0);
    set_all(MODE_LIGHT, 10'sd0, 8'sd100);
    send_pixel(8'd200, 8'd150, 8'd100, 0);
    send_pixel(8'd90, 8'd90, 8'd90, 0);
    set_all(MODE_LIGHT, 10'sd0, -8'sd100);
    send_pixel(8'd200, 8'd150, 8'd100, 0);
    set_all(MODE_NONE, 10'sd45, 8'sd50);
    send_pixel(8'd17, 8'd240, 8'd133, 0);
    drain();
  endtask

  task automatic test_random();
    int i;
    for (i = 0; i < 12; i++) begin
      set_all(mode_e'($urandom_range(0, 3)), 10'($urandom), 8'($urandom));
      // no gaps on a few phases
      random_pixels(100, (i % 4) != 1);
    end
    drain();
  endtask

  initial begin
    cur_mode = MODE_HUE; cur_angle = '0; cur_pct = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rx_idle = 1'b0;
    test_directed();
    test_random();
    $display("sent %0d pixels, %0d results checked over all adjust modes,", sent, seen);
    $display("angle and percent extremes, grey pixels and random stalls");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("hsl_color_adjust: match");
    end else begin
      $display("hsl_color_adjust: mismatch");
    end
    $finish;
  end

endmodule
